>>> design/ctcs_pkg.sv
package ctcs_pkg;

  // Scan mode codes
  localparam logic [2:0] ModeNormal  = 3'd0;
  localparam logic [2:0] ModeComment = 3'd1;
  localparam logic [2:0] ModeQuote   = 3'd2;
  localparam logic [2:0] ModeQuoteBs = 3'd3;
  localparam logic [2:0] ModeBs      = 3'd4;
  localparam logic [2:0] ModeSkipWs  = 3'd5;

  // Character codes
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Output burst for one input word: cnt bytes (1 or 2), b0 first
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } ctcs_rec_t;

endpackage

>>> design/ctcs_front.sv
module ctcs_front import ctcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  input  logic       q_full_i,
  output logic       push_o,
  output ctcs_rec_t  rec_o
);

  logic [2:0] mode_q, mode_d;
  logic       nl_seen_q, nl_seen_d;
  logic       any_q, any_d;
  logic       last_nl_q, last_nl_d;

  logic       accept;
  logic       is_ws;
  logic [1:0] cnt;
  logic [7:0] e0, e1;

  // Normal-mode handling of the current byte
  logic [2:0] nm_mode;
  logic       nm_emit;
  logic       nm_nl_seen;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign is_ws      = ((data_byte_i >= ChTab) && (data_byte_i <= ChCr)) ||
                      (data_byte_i == ChSpace);

  always_comb begin
    nm_mode    = ModeNormal;
    nm_emit    = 1'b1;
    nm_nl_seen = nl_seen_q;
    if (data_byte_i == ChHash) begin
      nm_emit = 1'b0;
      nm_mode = ModeComment;
    end else if (data_byte_i == ChQuote) begin
      nm_mode = ModeQuote;
    end else if (data_byte_i == ChBsl) begin
      nm_emit = 1'b0;
      nm_mode = ModeBs;
    end else if (data_byte_i == ChNl) begin
      // leading blank line is dropped
      nm_emit    = nl_seen_q | any_q;
      nm_nl_seen = 1'b1;
      nm_mode    = ModeSkipWs;
    end
  end

  // Mode decode and burst build
  always_comb begin
    mode_d    = mode_q;
    nl_seen_d = nl_seen_q;
    cnt       = 2'd0;
    e0        = data_byte_i;
    e1        = data_byte_i;
    if (end_of_text_i) begin
      mode_d    = ModeNormal;
      nl_seen_d = 1'b0;
      if ((mode_q == ModeBs) || (mode_q == ModeQuoteBs)) begin
        // dangling backslash, then closing newline
        cnt = 2'd2;
        e0  = ChBsl;
        e1  = ChNl;
      end else if (!last_nl_q) begin
        cnt = 2'd1;
        e0  = ChNl;
      end
    end else begin
      unique case (mode_q) inside
        ModeComment: begin
          if (data_byte_i == ChNl) begin
            cnt       = {1'b0, nm_emit};
            mode_d    = nm_mode;
            nl_seen_d = nm_nl_seen;
          end
        end
        ModeQuote: begin
          if (data_byte_i == ChBsl) begin
            mode_d = ModeQuoteBs;
          end else begin
            cnt = 2'd1;
            if (data_byte_i == ChQuote) mode_d = ModeNormal;
          end
        end
        ModeQuoteBs, ModeBs: begin
          if (data_byte_i == ChNl) begin
            cnt = 2'd1;
            e0  = ChSpace;
          end else begin
            cnt = 2'd2;
            e0  = ChBsl;
          end
          mode_d = (mode_q == ModeQuoteBs) ? ModeQuote : ModeNormal;
        end
        ModeSkipWs: begin
          if (!is_ws) begin
            cnt       = {1'b0, nm_emit};
            mode_d    = nm_mode;
            nl_seen_d = nm_nl_seen;
          end
        end
        default: begin
          cnt       = {1'b0, nm_emit};
          mode_d    = nm_mode;
          nl_seen_d = nm_nl_seen;
        end
      endcase
    end
  end

  // Emission flags
  always_comb begin
    any_d     = any_q;
    last_nl_d = last_nl_q;
    if (end_of_text_i) begin
      any_d     = 1'b0;
      last_nl_d = 1'b0;
    end else if (cnt == 2'd2) begin
      any_d     = 1'b1;
      last_nl_d = (e1 == ChNl);
    end else if (cnt == 2'd1) begin
      any_d     = 1'b1;
      last_nl_d = (e0 == ChNl);
    end
  end

  assign push_o     = accept & (cnt != 2'd0);
  assign rec_o.cnt  = cnt;
  assign rec_o.b0   = e0;
  assign rec_o.b1   = e1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeNormal;
      nl_seen_q <= 1'b0;
      any_q     <= 1'b0;
      last_nl_q <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      nl_seen_q <= nl_seen_d;
      any_q     <= any_d;
      last_nl_q <= last_nl_d;
    end
  end

endmodule

>>> design/ctcs_queue.sv
module ctcs_queue import ctcs_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ctcs_rec_t push_rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output ctcs_rec_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ctcs_rec_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_rec_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> design/ctcs_back.sv
module ctcs_back import ctcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  ctcs_rec_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       sel_q;       // next byte of head word to send
  logic       load;
  logic       head_last;

  assign load      = !valid_q || !out_stall_i;
  assign head_last = sel_q || (head_i.cnt == 2'd1);
  assign pop_o     = load && !q_empty_i && head_last;

  // Output register, one byte per cycle from the queue head while not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= !q_empty_i;
      if (!q_empty_i) sel_q <= !head_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_empty_i) begin
      byte_q <= sel_q ? head_i.b1 : head_i.b0;
      last_q <= head_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

endmodule

>>> design/config_text_comment_stripper_unit.sv
// Channel | valid      | stall      | payload
// input   | in_valid_i | in_stall_o | data_byte_i, end_of_text_i
// output  | out_valid_o| out_stall_i| out_byte_o, last_of_run_o
//
// One input word is taken per cycle while the word queue has room; its
// zero to two bytes leave one per cycle through the output register
// while the output is not stalled. A word is written to the word queue
// and then loaded, byte by byte, into the output register.
// Reset clears mode, flags, queue and output valid. Input stall is the
// queue-full flag; output stall holds the output register.
module config_text_comment_stripper_unit import ctcs_pkg::*; #(
  parameter int unsigned QDepth = 4   // word queue depth, 2 or more
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic      q_full, q_empty, push, pop;
  ctcs_rec_t push_rec, head_rec;

  // Decode and state update
  ctcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  // Word queue
  ctcs_queue #(.Depth(QDepth)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_rec)
  );

  // Byte serializer
  ctcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
